FILE: rtl/priority_bitmap_scheduler_defines.svh
// Assertion macros for the scheduler RTL
`ifndef PRIORITY_BITMAP_SCHEDULER_DEFINES_SVH
`define PRIORITY_BITMAP_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while in reset
`define PBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while in reset
`define PBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pbs_pkg.sv
`timescale 1ns / 1ps

package pbs_pkg;

    localparam int TASK_SLOTS_DEF = 64;
    localparam logic [7:0] DEPTH_MAX = 8'hFF;

    typedef enum logic [3:0] {
        CMD_CREATE    = 4'd0,
        CMD_READY     = 4'd1,
        CMD_UNREADY   = 4'd2,
        CMD_INT_ENTER = 4'd3,
        CMD_INT_EXIT  = 4'd4,
        CMD_LOCK      = 4'd5,
        CMD_UNLOCK    = 4'd6,
        CMD_SCHEDULE  = 4'd7,
        CMD_START     = 4'd8
    } pbs_cmd_t;

    typedef enum logic [1:0] {
        KIND_TASK  = 2'd0,
        KIND_INT   = 2'd1,
        KIND_START = 2'd2
    } pbs_kind_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic [5:0] prio;
    } pbs_in_t;

    typedef struct packed {
        logic        switch_now;
        logic [1:0]  switch_kind;
        logic [5:0]  next_prio;
        logic        status;
        logic [7:0]  int_depth;
        logic [7:0]  lock_depth;
        logic [31:0] switch_total;
    } pbs_out_t;

    // Ready-map update ordered by the control unit
    typedef struct packed {
        logic       set;
        logic       clr;
        logic [5:0] prio;
    } pbs_map_upd_t;

    // Control state visible to the top level
    typedef struct packed {
        logic        running;
        logic [7:0]  int_nest;
        logic [7:0]  lock_nest;
        logic [31:0] switch_count;
    } pbs_stat_t;

    // Index of the lowest set bit; 0 for an empty byte
    function automatic logic [2:0] low_bit(input logic [7:0] v);
        logic [2:0] res;
        res = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                res = 3'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/priority_bitmap_scheduler.sv
`timescale 1ns / 1ps
// Ready-list scheduler for 64 priority levels (0 is highest). Each command item
// on the cmd channel yields exactly one result item on the res channel. The block
// takes one command per cycle while cmd_stall is low. An accepted command is held
// in the input register; its result is loaded into the result register when the
// staged item advances, which a stalled result can hold off. The ready-map
// encode, the nesting/switch logic and the ready-map update are done
// combinationally between the input register and the result register. A stalled
// result holds the pipeline; commands are refused only while both registers are
// full and the result is stalled.

`include "priority_bitmap_scheduler_defines.svh"

module priority_bitmap_scheduler
    import pbs_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  pbs_in_t  cmd_item,
    output logic     res_valid,
    input  logic     res_stall,
    output pbs_out_t res_item
);

    logic         stage_valid_reg;
    pbs_in_t      stage_item_reg;
    logic         res_valid_reg;
    pbs_out_t     res_item_reg;
    logic         adv;
    logic         accept;
    logic [5:0]   highest;
    pbs_map_upd_t upd;
    pbs_out_t     result;
    pbs_stat_t    stat;
    logic         res_sw;
    logic [1:0]   res_kind;
    logic         nested;
    logic [31:0]  sw_cnt;

    // Advance the staged item when the result register is free or draining
    assign adv       = stage_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = stage_valid_reg && !adv;
    assign accept    = cmd_valid && !cmd_stall;

    pbs_ready_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .upd     (upd),
        .highest (highest)
    );

    pbs_ctrl #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .item    (stage_item_reg),
        .highest (highest),
        .upd     (upd),
        .result  (result),
        .stat    (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= cmd_item;
        end
        if (adv)
        begin
            res_item_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    assign res_sw   = res_item.switch_now;
    assign res_kind = res_item.switch_kind;
    assign nested   = (stat.int_nest != 8'd0) || (stat.lock_nest != 8'd0);
    assign sw_cnt   = stat.switch_count;

    `PBS_ASSERT_IMPL(a_kind_no_switch, res_valid && !res_sw, res_kind == KIND_TASK, "stray kind")
    `PBS_ASSERT_IMPL(a_nest_running, nested, stat.running, "nesting before start")
    `PBS_ASSERT_NEXT(a_count_step, 1'b1, sw_cnt - $past(sw_cnt) <= 32'd1, "count jumped")
    `PBS_ASSERT_IMPL(a_stall_when_full, cmd_stall, res_valid && res_stall, "stall with room")

endmodule

FILE: rtl/pbs_ready_map.sv
`timescale 1ns / 1ps

module pbs_ready_map
    import pbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  pbs_map_upd_t upd,
    output logic [5:0]   highest
);

    logic [7:0] group_reg;
    logic [7:0] group_next;
    logic [7:0] rows_reg  [8];
    logic [7:0] rows_next [8];
    logic [2:0] row_low   [8];
    logic [2:0] upd_row;
    logic [7:0] col_bit;
    logic [2:0] grp_low;

    assign upd_row = upd.prio[5:3];
    assign col_bit = 8'd1 << upd.prio[2:0];

    always_comb
    begin
        group_next = group_reg;
        for (int r = 0; r < 8; r++)
        begin
            rows_next[r] = rows_reg[r];
            row_low[r]   = low_bit(rows_reg[r]);
            if (upd_row == 3'(r))
            begin
                if (upd.set)
                begin
                    rows_next[r]  = rows_reg[r] | col_bit;
                    group_next[r] = 1'b1;
                end
                else if (upd.clr)
                begin
                    rows_next[r]  = rows_reg[r] & ~col_bit;
                    group_next[r] = group_reg[r] & (rows_next[r] != 8'd0);
                end
            end
        end
    end

    // Two-level encode: lowest ready row, then lowest ready column in it
    assign grp_low = low_bit(group_reg);
    assign highest = {grp_low, row_low[grp_low]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= 8'd0;
            for (int r = 0; r < 8; r++)
            begin
                rows_reg[r] <= 8'd0;
            end
        end
        else if (en)
        begin
            group_reg <= group_next;
            for (int r = 0; r < 8; r++)
            begin
                rows_reg[r] <= rows_next[r];
            end
        end
    end

endmodule

FILE: rtl/pbs_ctrl.sv
`timescale 1ns / 1ps

module pbs_ctrl
    import pbs_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  pbs_in_t      item,
    input  logic [5:0]   highest,
    output pbs_map_upd_t upd,
    output pbs_out_t     result,
    output pbs_stat_t    stat
);

    localparam int CW = $clog2(TASK_SLOTS + 1);

    logic          running_reg,  running_next;
    logic [7:0]    int_reg,      int_next;
    logic [7:0]    lock_reg,     lock_next;
    logic [5:0]    cur_reg,      cur_next;
    logic [31:0]   cnt_reg,      cnt_next;
    logic [CW-1:0] tasks_reg,    tasks_next;
    logic          try_sw;
    logic          searched;
    logic          sw;
    logic          status;
    pbs_kind_t     kind;

    always_comb
    begin
        running_next = running_reg;
        int_next     = int_reg;
        lock_next    = lock_reg;
        cur_next     = cur_reg;
        cnt_next     = cnt_reg;
        tasks_next   = tasks_reg;
        upd.set      = 1'b0;
        upd.clr      = 1'b0;
        upd.prio     = item.prio;
        try_sw       = 1'b0;
        searched     = 1'b0;
        sw           = 1'b0;
        status       = 1'b0;
        kind         = KIND_TASK;

        case (item.cmd)
            CMD_CREATE:
            begin
                if (tasks_reg < CW'(TASK_SLOTS))
                begin
                    tasks_next = tasks_reg + CW'(1);
                    upd.set    = 1'b1;
                end
                else
                begin
                    status = 1'b1;
                end
            end
            CMD_READY:
            begin
                upd.set = 1'b1;
            end
            CMD_UNREADY:
            begin
                upd.clr = 1'b1;
            end
            CMD_INT_ENTER:
            begin
                if (running_reg && int_reg != DEPTH_MAX)
                begin
                    int_next = int_reg + 8'd1;
                end
            end
            CMD_INT_EXIT:
            begin
                if (running_reg)
                begin
                    if (int_reg != 8'd0)
                    begin
                        int_next = int_reg - 8'd1;
                    end
                    try_sw = 1'b1;
                    kind   = KIND_INT;
                end
            end
            CMD_LOCK:
            begin
                if (running_reg && lock_reg != DEPTH_MAX)
                begin
                    lock_next = lock_reg + 8'd1;
                end
            end
            CMD_UNLOCK:
            begin
                if (running_reg && lock_reg != 8'd0)
                begin
                    lock_next = lock_reg - 8'd1;
                    try_sw    = 1'b1;
                end
            end
            CMD_SCHEDULE:
            begin
                try_sw = 1'b1;
            end
            CMD_START:
            begin
                if (!running_reg)
                begin
                    searched     = 1'b1;
                    cur_next     = highest;
                    running_next = 1'b1;
                    sw           = 1'b1;
                    kind         = KIND_START;
                end
            end
            default:
            begin
            end
        endcase

        // Search only with both nesting depths at zero after the command
        if (try_sw && int_next == 8'd0 && lock_next == 8'd0)
        begin
            searched = 1'b1;
            if (highest != cur_reg)
            begin
                sw       = 1'b1;
                cur_next = highest;
                cnt_next = cnt_reg + 32'd1;
            end
        end

        if (!sw)
        begin
            kind = KIND_TASK;
        end

        result.switch_now   = sw;
        result.switch_kind  = kind;
        result.next_prio    = searched ? highest : cur_reg;
        result.status       = status;
        result.int_depth    = int_next;
        result.lock_depth   = lock_next;
        result.switch_total = cnt_next;
    end

    assign stat.running      = running_reg;
    assign stat.int_nest     = int_reg;
    assign stat.lock_nest    = lock_reg;
    assign stat.switch_count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            int_reg     <= 8'd0;
            lock_reg    <= 8'd0;
            cur_reg     <= 6'd0;
            cnt_reg     <= 32'd0;
            tasks_reg   <= '0;
        end
        else if (en)
        begin
            running_reg <= running_next;
            int_reg     <= int_next;
            lock_reg    <= lock_next;
            cur_reg     <= cur_next;
            cnt_reg     <= cnt_next;
            tasks_reg   <= tasks_next;
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pbs_pkg::*;

    localparam int SLOTS = TASK_SLOTS_DEF;
    // Codes past the last command; the block must report state and do nothing
    localparam logic [3:0] CMD_SPARE_FIRST = 4'd9;
    localparam logic [3:0] CMD_SPARE_LAST = 4'd15;
    localparam int RANDOM_ITEMS = 400;
    localparam int FLOOD_DEPTH = 258;
    // Longest quiet stretch: sender gaps and receiver stall runs stay well below this
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } rx_mode_t;

    class sched_scoreboard;
        logic [7:0] grp;
        logic [7:0] rows [8];
        logic [5:0] cur_prio;
        logic [7:0] int_nest;
        logic [7:0] lock_nest;
        bit running;
        logic [31:0] switches;
        int unsigned used;
        pbs_out_t expected_q [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned refusals;
        int unsigned max_int;
        int unsigned max_lock;

        function new();
            grp = '0;
            foreach (rows[i])
            begin
                rows[i] = '0;
            end
            cur_prio = '0;
            int_nest = '0;
            lock_nest = '0;
            running = 1'b0;
            switches = '0;
            used = 0;
            errors = 0;
            checked = 0;
            refusals = 0;
            max_int = 0;
            max_lock = 0;
        endfunction

        // Lowest set group bit, then lowest set bit of that row; empty gives 0
        function logic [5:0] top_ready();
            logic [2:0] y;
            logic [2:0] x;
            y = '0;
            x = '0;
            for (int i = 7; i >= 0; i--)
            begin
                if (grp[i])
                begin
                    y = 3'(i);
                end
            end
            for (int i = 7; i >= 0; i--)
            begin
                if (rows[y][i])
                begin
                    x = 3'(i);
                end
            end
            return {y, x};
        endfunction

        function bit search_and_switch(inout logic [5:0] found);
            if (int_nest != 0 || lock_nest != 0)
            begin
                return 1'b0;
            end
            found = top_ready();
            if (found == cur_prio)
            begin
                return 1'b0;
            end
            cur_prio = found;
            switches++;
            return 1'b1;
        endfunction

        // Pick a priority that is currently ready, or a random one if none is
        function logic [5:0] pick_ready();
            logic [5:0] start;
            logic [5:0] p;
            start = 6'($urandom_range(0, 63));
            for (int k = 0; k < 64; k++)
            begin
                p = start + 6'(k);
                if (rows[p[5:3]][p[2:0]])
                begin
                    return p;
                end
            end
            return start;
        endfunction

        function void note_cmd(pbs_in_t it);
            pbs_out_t r;
            logic [2:0] row;
            logic [7:0] col_bit;
            logic [5:0] nxt;
            bit sw;
            r = '0;
            row = it.prio[5:3];
            col_bit = 8'd1 << it.prio[2:0];
            nxt = cur_prio;
            sw = 1'b0;
            case (it.cmd)
                CMD_CREATE:
                begin
                    if (used < SLOTS)
                    begin
                        used++;
                        grp[row] = 1'b1;
                        rows[row] |= col_bit;
                    end
                    else
                    begin
                        r.status = 1'b1;
                        refusals++;
                    end
                end
                CMD_READY:
                begin
                    grp[row] = 1'b1;
                    rows[row] |= col_bit;
                end
                CMD_UNREADY:
                begin
                    rows[row] &= ~col_bit;
                    if (rows[row] == 0)
                    begin
                        grp[row] = 1'b0;
                    end
                end
                CMD_INT_ENTER:
                begin
                    if (running && int_nest != DEPTH_MAX)
                    begin
                        int_nest++;
                    end
                end
                CMD_INT_EXIT:
                begin
                    if (running)
                    begin
                        if (int_nest != 0)
                        begin
                            int_nest--;
                        end
                        sw = search_and_switch(nxt);
                        if (sw)
                        begin
                            r.switch_kind = KIND_INT;
                        end
                    end
                end
                CMD_LOCK:
                begin
                    if (running && lock_nest != DEPTH_MAX)
                    begin
                        lock_nest++;
                    end
                end
                CMD_UNLOCK:
                begin
                    if (running && lock_nest != 0)
                    begin
                        lock_nest--;
                        sw = search_and_switch(nxt);
                    end
                end
                CMD_SCHEDULE:
                begin
                    sw = search_and_switch(nxt);
                end
                CMD_START:
                begin
                    if (!running)
                    begin
                        nxt = top_ready();
                        cur_prio = nxt;
                        running = 1'b1;
                        sw = 1'b1;
                        r.switch_kind = KIND_START;
                    end
                end
                default:
                begin
                end
            endcase
            if (int_nest > max_int)
            begin
                max_int = int_nest;
            end
            if (lock_nest > max_lock)
            begin
                max_lock = lock_nest;
            end
            r.switch_now = sw;
            r.next_prio = nxt;
            r.int_depth = int_nest;
            r.lock_depth = lock_nest;
            r.switch_total = switches;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                    checked, name, got, want));
            end
        endtask

        task check_res(pbs_out_t got);
            pbs_out_t want;
            if (expected_q.size() == 0)
            begin
                report("result arrived with no command outstanding");
                return;
            end
            want = expected_q.pop_front();
            cmp_field("switch_now", 32'(got.switch_now), 32'(want.switch_now));
            cmp_field("switch_kind", 32'(got.switch_kind), 32'(want.switch_kind));
            cmp_field("next_prio", 32'(got.next_prio), 32'(want.next_prio));
            cmp_field("status", 32'(got.status), 32'(want.status));
            cmp_field("int_depth", 32'(got.int_depth), 32'(want.int_depth));
            cmp_field("lock_depth", 32'(got.lock_depth), 32'(want.lock_depth));
            cmp_field("switch_total", got.switch_total, want.switch_total);
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    pbs_in_t cmd_item;
    logic res_valid;
    logic res_stall;
    pbs_out_t res_item;

    sched_scoreboard sb;
    int items_sent = 0;
    int burst_left = 0;
    rx_mode_t stall_mode = RX_FREE;
    int stall_left = 0;

    priority_bitmap_scheduler #(
        .TASK_SLOTS(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_item(cmd_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_item(res_item)
    );

    always #5 clk = ~clk;

    // Receiver: switch to a randomly chosen stall pattern after each random-length run
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            RX_FREE:   res_stall <= 1'b0;
            RX_LIGHT:  res_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:  res_stall <= ($urandom_range(0, 3) != 0);
            default:   res_stall <= ~res_stall;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            sb.check_res(res_item);
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("[%0t] TIMEOUT: nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Drive one item; open a new burst after a random gap when the last one ran out
    task automatic send_cmd(input logic [3:0] code, input logic [5:0] p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item <= '{cmd: code, prio: p};
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        sb.note_cmd(cmd_item);
        burst_left--;
        items_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic touch_map();
        if ($urandom_range(0, 1) == 1)
        begin
            send_cmd(CMD_READY, 6'($urandom_range(0, 63)));
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            send_cmd(CMD_UNREADY, 6'($urandom_range(0, 63)));
        end
        else
        begin
            send_cmd(CMD_UNREADY, sb.pick_ready());
        end
    endtask

    // One short, mostly well-formed burst of scheduler activity
    task automatic random_activity();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            send_cmd(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
        end
        else if (pick < 35)
        begin
            repeat ($urandom_range(1, 6))
            begin
                send_cmd(CMD_CREATE, 6'($urandom_range(0, 63)));
            end
        end
        else if (pick < 55)
        begin
            repeat ($urandom_range(1, 3))
            begin
                touch_map();
            end
            send_cmd(CMD_SCHEDULE, 6'($urandom_range(0, 63)));
        end
        else if (pick < 75)
        begin
            send_cmd(CMD_INT_ENTER, 6'($urandom_range(0, 63)));
            repeat ($urandom_range(0, 3))
            begin
                touch_map();
            end
            if ($urandom_range(0, 2) == 0)
            begin
                send_cmd(CMD_INT_ENTER, 6'($urandom_range(0, 63)));
                touch_map();
                send_cmd(CMD_INT_EXIT, 6'($urandom_range(0, 63)));
            end
            send_cmd(CMD_INT_EXIT, 6'($urandom_range(0, 63)));
        end
        else if (pick < 90)
        begin
            send_cmd(CMD_LOCK, 6'($urandom_range(0, 63)));
            repeat ($urandom_range(0, 3))
            begin
                touch_map();
            end
            if ($urandom_range(0, 1) == 1)
            begin
                send_cmd(CMD_SCHEDULE, 6'($urandom_range(0, 63)));
            end
            send_cmd(CMD_UNLOCK, 6'($urandom_range(0, 63)));
        end
        else
        begin
            touch_map();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_item = '0;
        res_stall = 1'b0;
        sb = new();
        repeat (11)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        // Before start: empty search, ignored nesting commands, schedule while stopped
        send_cmd(CMD_SCHEDULE, 6'd0);
        send_cmd(CMD_INT_ENTER, 6'd0);
        send_cmd(CMD_LOCK, 6'd0);
        send_cmd(CMD_UNLOCK, 6'd0);
        send_cmd(CMD_INT_EXIT, 6'd0);
        send_cmd(CMD_CREATE, 6'd63);
        send_cmd(CMD_SCHEDULE, 6'd0);
        send_cmd(CMD_UNREADY, 6'd63);
        // First start on an empty map, then a second start that must do nothing
        send_cmd(CMD_START, 6'd0);
        send_cmd(CMD_START, 6'd0);
        send_cmd(CMD_SPARE_LAST, 6'd63);
        send_cmd(CMD_SPARE_FIRST, 6'd42);
        send_cmd(CMD_READY, 6'd0);
        send_cmd(CMD_UNREADY, 6'd0);
        send_cmd(CMD_READY, 6'd36);
        send_cmd(CMD_INT_ENTER, 6'd0);
        send_cmd(CMD_READY, 6'd27);
        send_cmd(CMD_INT_EXIT, 6'd0);
        send_cmd(CMD_LOCK, 6'd0);
        send_cmd(CMD_UNREADY, 6'd27);
        send_cmd(CMD_SCHEDULE, 6'd0);
        send_cmd(CMD_UNLOCK, 6'd0);
        send_cmd(CMD_CREATE, 6'd0);
        // Exit with no interrupt open: depth stays at zero but the search still runs
        send_cmd(CMD_INT_EXIT, 6'd0);

        hold_until_drained();
        while (items_sent < 24 + RANDOM_ITEMS)
        begin
            random_activity();
        end

        // Drive both nesting depths into saturation
        hold_until_drained();
        for (int i = 0; i < FLOOD_DEPTH; i++)
        begin
            send_cmd(CMD_LOCK, 6'($urandom_range(0, 63)));
            if (i % 40 == 7)
            begin
                touch_map();
                send_cmd(CMD_SCHEDULE, 6'($urandom_range(0, 63)));
            end
        end
        repeat (3)
        begin
            send_cmd(CMD_UNLOCK, 6'($urandom_range(0, 63)));
        end
        for (int i = 0; i < FLOOD_DEPTH; i++)
        begin
            send_cmd(CMD_INT_ENTER, 6'($urandom_range(0, 63)));
            if (i % 40 == 11)
            begin
                send_cmd(CMD_CREATE, 6'($urandom_range(0, 63)));
            end
        end
        repeat (3)
        begin
            send_cmd(CMD_INT_EXIT, 6'($urandom_range(0, 63)));
        end

        hold_until_drained();
        repeat (8)
        begin
            @(posedge clk);
        end

        $display("Sent %0d commands, checked %0d results, %0d switches, %0d creates refused",
            items_sent, sb.checked, sb.switches, sb.refusals);
        $display("Deepest interrupt nesting %0d, deepest lock nesting %0d",
            sb.max_int, sb.max_lock);
        if (sb.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: priority_bitmap_scheduler.f
+incdir+rtl
rtl/pbs_pkg.sv
rtl/pbs_ready_map.sv
rtl/pbs_ctrl.sv
rtl/priority_bitmap_scheduler.sv
tb/testbench.sv
